@@ rtl/tcpop_pkg.sv @@
// tcpop_pkg: beat types, command and result codes, parser phases and sizes
// for the tcp option parser; no dependencies
package tcpop_pkg;

	localparam int MAX_OPTION_BYTES_DEF = 40;
	localparam int POS_W                = 6;
	localparam int IDX_W                = 5;
	localparam int KIND_W               = 8;
	localparam int KINDS                = 256;

	localparam logic [1:0] CMD_BYTE  = 2'd0;
	localparam logic [1:0] CMD_QUERY = 2'd1;
	localparam logic [1:0] CMD_BEGIN = 2'd2;

	localparam logic [1:0] RK_RECORD  = 2'd0;
	localparam logic [1:0] RK_SUMMARY = 2'd1;
	localparam logic [1:0] RK_QUERY   = 2'd2;

	localparam logic [KIND_W-1:0] KIND_EOL = 8'd0;
	localparam logic [KIND_W-1:0] KIND_NOP = 8'd1;
	localparam logic [KIND_W-1:0] HDR_LEN  = 8'd2;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_KIND,
		PH_LEN,
		PH_BODY,
		PH_ENDED,
		PH_BROKEN
	} phase_t;

	typedef struct packed {
		logic [1:0]        cmd;
		logic              last_byte;
		logic [KIND_W-1:0] byte_value;
	} in_beat_t;

	typedef struct packed {
		logic [1:0]        result_kind;
		logic [KIND_W-1:0] option_kind;
		logic [POS_W-1:0]  option_offset;
		logic [POS_W-1:0]  body_length;
		logic [IDX_W-1:0]  option_index;
		logic              present;
		logic              parse_ok;
		logic [IDX_W-1:0]  option_count;
		logic              last_result;
	} out_beat_t;

endpackage

@@ rtl/tcpop_ram.sv @@
// tcpop_ram: generic single-write, single-read ram with registered read data
// no dependencies
module tcpop_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

@@ rtl/tcp_option_parser_unit.sv @@
// tcp_option_parser_unit: streaming parser for the tcp header option area
// depends on tcpop_pkg and tcpop_ram
//
// Takes one option-area byte, query or begin command per beat and can accept
// a beat every cycle while the output has room. Each beat is registered into
// stage 1, where the parser phase, the 256-bit presence map and the kind
// index ram are updated together; results go to a two-slot output register.
// A beat that yields one result (or none) keeps the rate at one beat per
// cycle while the receiver takes results; a last byte that completes an
// option yields a record and a summary, which fill both output slots, so the
// next beat with a result holds until the summary moves up. The index ram is
// read when a query is accepted and a same-cycle index write is forwarded,
// so queries see every option completed before them. No clearing pass:
// presence bits clear on begin and reset; only present kinds use ram data.
module tcp_option_parser_unit
	import tcpop_pkg::*;
#(
	parameter int MAX_OPTION_BYTES = MAX_OPTION_BYTES_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      opt_valid,
	output logic      opt_ready,
	input  in_beat_t  opt_data,
	output logic      res_valid,
	input  logic      res_ready,
	output out_beat_t res_data
);

	// stage 1 input register
	logic     s1_v_q;
	in_beat_t s1_q;
	logic     s1_fire;
	logic     opt_acc;

	// parser state
	phase_t            phase_q, phase_d, ph_mid;
	logic [POS_W-1:0]  pos_q, pos_d, pos_inc;
	logic [KIND_W-1:0] kind_q, kind_d;
	logic [POS_W-1:0]  rem_q, rem_d, rem_dec;
	logic [POS_W-1:0]  start_q, start_d;
	logic [IDX_W-1:0]  count_q, count_d;
	logic [KINDS-1:0]  found_q;
	logic [KIND_W-1:0] len_lim;

	// per-beat decisions
	logic             rec_hit, sum_hit, qry_hit, clr_hit;
	logic [POS_W-1:0] dlen;

	// index ram and write forwarding
	logic [IDX_W-1:0]  ram_rd;
	logic              wr_en;
	logic              fwd_v_q;
	logic [KIND_W-1:0] fwd_addr_q;
	logic [IDX_W-1:0]  fwd_data_q;
	logic [IDX_W-1:0]  qry_idx;
	logic              qry_pres;

	// results
	out_beat_t rec_beat, sum_beat, qry_beat, r0, r1;
	logic [1:0] n_res;

	// two-slot output register
	logic      out_v_q, ex_v_q;
	out_beat_t out_q, ex_q;
	logic      out_room;

	assign opt_acc   = opt_valid && opt_ready;
	assign opt_ready = !s1_v_q || s1_fire;
	assign out_room  = !ex_v_q && (!out_v_q || res_ready);
	assign s1_fire   = s1_v_q && ((n_res == 2'd0) || out_room);
	assign wr_en     = s1_fire && rec_hit;

	assign pos_inc = pos_q + POS_W'(1);
	assign rem_dec = (rem_q != '0) ? rem_q - POS_W'(1) : rem_q;
	// room left in the area from this option's kind byte on
	assign len_lim = KIND_W'(MAX_OPTION_BYTES) - {{(KIND_W-POS_W){1'b0}}, start_q};

	tcpop_ram #(
		.WIDTH (IDX_W),
		.DEPTH (KINDS)
	) u_idx_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (kind_q),
		.wr_data (count_q),
		.rd_en   (opt_acc),
		.rd_addr (opt_data.byte_value),
		.rd_data (ram_rd)
	);

	// next state of the parser
	always_comb begin
		ph_mid  = phase_q;
		pos_d   = pos_q;
		kind_d  = kind_q;
		rem_d   = rem_q;
		start_d = start_q;
		count_d = count_q;
		rec_hit = 1'b0;
		sum_hit = 1'b0;
		qry_hit = 1'b0;
		clr_hit = 1'b0;
		dlen    = '0;
		case (s1_q.cmd)
			CMD_BEGIN: begin
				clr_hit = 1'b1;
				ph_mid  = PH_KIND;
				pos_d   = '0;
				kind_d  = '0;
				rem_d   = '0;
				start_d = '0;
				count_d = '0;
			end
			CMD_QUERY: begin
				qry_hit = 1'b1;
			end
			CMD_BYTE: begin
				if (phase_q != PH_IDLE) begin
					if (pos_q >= POS_W'(MAX_OPTION_BYTES)) begin
						// oversized area
						ph_mid = PH_BROKEN;
					end else begin
						pos_d = pos_inc;
						case (phase_q)
							PH_KIND: begin
								if (s1_q.byte_value == KIND_EOL) begin
									ph_mid = PH_ENDED;
								end else if (s1_q.byte_value != KIND_NOP) begin
									kind_d  = s1_q.byte_value;
									start_d = pos_q;
									ph_mid  = s1_q.last_byte ? PH_BROKEN : PH_LEN;
								end
							end
							PH_LEN: begin
								if (s1_q.byte_value < HDR_LEN || s1_q.byte_value > len_lim) begin
									ph_mid = PH_BROKEN;
								end else if (s1_q.byte_value == HDR_LEN) begin
									rec_hit = 1'b1;
									ph_mid  = PH_KIND;
								end else begin
									rem_d  = POS_W'(s1_q.byte_value - HDR_LEN);
									ph_mid = s1_q.last_byte ? PH_BROKEN : PH_BODY;
								end
							end
							PH_BODY: begin
								rem_d = rem_dec;
								if (rem_dec == '0) begin
									rec_hit = 1'b1;
									dlen    = pos_inc - start_q - POS_W'(HDR_LEN);
									ph_mid  = PH_KIND;
								end else if (s1_q.last_byte) begin
									ph_mid = PH_BROKEN;
								end
							end
							default: begin
							end
						endcase
					end
					if (rec_hit && count_q != '1) begin
						count_d = count_q + IDX_W'(1);
					end
					sum_hit = s1_q.last_byte;
				end
			end
			default: begin
			end
		endcase
		phase_d = sum_hit ? PH_IDLE : ph_mid;
	end

	// query answer, with the index written in the load cycle forwarded
	assign qry_pres = found_q[s1_q.byte_value];
	assign qry_idx  = (fwd_v_q && fwd_addr_q == s1_q.byte_value) ? fwd_data_q : ram_rd;

	// result beats
	always_comb begin
		rec_beat               = '0;
		rec_beat.result_kind   = RK_RECORD;
		rec_beat.option_kind   = kind_q;
		rec_beat.option_offset = start_q;
		rec_beat.body_length   = dlen;
		rec_beat.option_index  = count_q;
		rec_beat.last_result   = !sum_hit;

		sum_beat              = '0;
		sum_beat.result_kind  = RK_SUMMARY;
		sum_beat.parse_ok     = (ph_mid != PH_BROKEN);
		sum_beat.option_count = count_d;
		sum_beat.last_result  = 1'b1;

		qry_beat              = '0;
		qry_beat.result_kind  = RK_QUERY;
		qry_beat.option_kind  = s1_q.byte_value;
		qry_beat.present      = qry_pres;
		qry_beat.option_index = qry_pres ? qry_idx : '0;
		qry_beat.last_result  = 1'b1;

		r1    = sum_beat;
		n_res = 2'd0;
		r0    = sum_beat;
		if (qry_hit) begin
			r0    = qry_beat;
			n_res = 2'd1;
		end else if (rec_hit) begin
			r0    = rec_beat;
			n_res = sum_hit ? 2'd2 : 2'd1;
		end else if (sum_hit) begin
			n_res = 2'd1;
		end
	end

	// stage 1 and forwarding registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q  <= 1'b0;
			fwd_v_q <= 1'b0;
		end else begin
			if (opt_acc) begin
				s1_v_q  <= 1'b1;
				fwd_v_q <= wr_en;
			end else if (s1_fire) begin
				s1_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (opt_acc) begin
			s1_q       <= opt_data;
			fwd_addr_q <= kind_q;
			fwd_data_q <= count_q;
		end
	end

	// parser state registers; reset looks like a begin
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_KIND;
			pos_q   <= '0;
			kind_q  <= '0;
			rem_q   <= '0;
			start_q <= '0;
			count_q <= '0;
			found_q <= '0;
		end else if (s1_fire) begin
			phase_q <= phase_d;
			pos_q   <= pos_d;
			kind_q  <= kind_d;
			rem_q   <= rem_d;
			start_q <= start_d;
			count_q <= count_d;
			if (clr_hit) begin
				found_q <= '0;
			end else if (rec_hit) begin
				found_q[kind_q] <= 1'b1;
			end
		end
	end

	// output slots: out_q is shown, ex_q holds the summary behind a record
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			ex_v_q  <= 1'b0;
		end else begin
			if (s1_fire && n_res != 2'd0) begin
				out_v_q <= 1'b1;
				ex_v_q  <= (n_res == 2'd2);
			end else if (out_v_q && res_ready) begin
				if (ex_v_q) begin
					ex_v_q <= 1'b0;
				end else begin
					out_v_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire && n_res != 2'd0) begin
			out_q <= r0;
			ex_q  <= r1;
		end else if (out_v_q && res_ready && ex_v_q) begin
			out_q <= ex_q;
		end
	end

	assign res_valid = out_v_q;
	assign res_data  = out_q;

`ifndef SYNTHESIS
	a_ex_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		ex_v_q |-> out_v_q)
		else $error("second result slot full while first is empty");

	a_pair_fills_ex: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_fire && n_res == 2'd2) |=> ex_v_q)
		else $error("record plus summary did not fill both slots");

	a_not_last_has_tail: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_data.last_result) |-> ex_v_q)
		else $error("non-final result shown with nothing behind it");

	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= POS_W'(MAX_OPTION_BYTES))
		else $error("byte position beyond option area");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= IDX_W'(MAX_OPTION_BYTES / 2))
		else $error("more records than the area can hold");
`endif

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 100ps
// tb_top: self-checking bench for tcp_option_parser_unit, one option-area byte per beat
// depends on tcpop_pkg and the parser rtl; every result beat is checked against a local predictor
module tb_top
	import tcpop_pkg::*;
();

	localparam int         HALF_PERIOD  = 2;
	localparam int         AREA_MAX     = MAX_OPTION_BYTES_DEF;
	localparam int         BEAT_TARGET  = 1450;
	localparam logic [1:0] CMD_UNUSED   = 2'd3;

	// one row of the directed stimulus; want is only used when typed is set
	typedef struct {
		in_beat_t  beat;
		bit        typed;
		out_beat_t want;
	} stim_row_t;

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      opt_valid = 1'b0;
	logic      opt_ready;
	in_beat_t  opt_data  = '0;
	logic      res_valid;
	logic      res_ready = 1'b0;
	out_beat_t res_data;

	// predictor state, mirrors the parser after each accepted beat
	phase_t     ph;
	logic [5:0] area_pos;
	logic [7:0] cur_kind;
	logic [5:0] body_left;
	logic [5:0] opt_start;
	logic [4:0] rec_count;
	logic [KINDS-1:0] kinds_seen;
	logic [4:0] kind_slot [KINDS];

	out_beat_t pending_results [$];
	stim_row_t directed_rows [$];
	logic [7:0] area_bytes [$];

	int  beats_counted;
	int  beats_made;        // results produced by the most recent beat
	int  mismatches;
	int  areas_run;
	int  records_seen;
	int  summaries_seen;
	int  broken_seen;
	int  queries_seen;
	int  query_hits;
	bit  stalls_on = 1'b1;

	tcp_option_parser_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.opt_valid (opt_valid),
		.opt_ready (opt_ready),
		.opt_data  (opt_data),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_data  (res_data)
	);

	always #HALF_PERIOD clk = ~clk;

	// receiver: ready drops at random, about 8 percent of the time, while stalls are on
	always @(posedge clk) begin
		res_ready <= !(stalls_on && $urandom_range(0, 99) < 8);
	end

	// ---------------------------------------------------------------------
	// predictor
	// ---------------------------------------------------------------------

	// start of a new option area, also the state right after reset
	function automatic void open_area();
		ph         = PH_KIND;
		area_pos   = '0;
		cur_kind   = '0;
		body_left  = '0;
		opt_start  = '0;
		rec_count  = '0;
		kinds_seen = '0;
	endfunction

	// a complete option: mark the kind present, remember its option index
	function automatic out_beat_t note_option(logic [5:0] dlen);
		out_beat_t r;
		r = '0;
		r.result_kind   = RK_RECORD;
		r.option_kind   = cur_kind;
		r.option_offset = opt_start;
		r.body_length   = dlen;
		r.option_index  = rec_count;
		kinds_seen[cur_kind] = 1'b1;
		kind_slot[cur_kind]  = rec_count;
		if (rec_count < 5'd31)
			rec_count++;
		return r;
	endfunction

	// works out the result beats for one accepted input beat
	task automatic parse_beat(input in_beat_t b);
		out_beat_t  outs [2];
		int         n;
		logic [5:0] at;
		n = 0;
		if (b.cmd == CMD_BEGIN) begin
			open_area();
		end else if (b.cmd == CMD_QUERY) begin
			outs[0] = '0;
			outs[0].result_kind  = RK_QUERY;
			outs[0].option_kind  = b.byte_value;
			outs[0].present      = kinds_seen[b.byte_value];
			outs[0].option_index = kinds_seen[b.byte_value] ? kind_slot[b.byte_value] : 5'd0;
			n = 1;
		end else if (b.cmd == CMD_BYTE && ph != PH_IDLE) begin
			if (int'(area_pos) >= AREA_MAX) begin
				// byte past the end of the option area
				ph = PH_BROKEN;
			end else begin
				at = area_pos;
				area_pos++;
				case (ph)
					PH_KIND: begin
						if (b.byte_value == KIND_EOL) begin
							ph = PH_ENDED;
						end else if (b.byte_value != KIND_NOP) begin
							cur_kind  = b.byte_value;
							opt_start = at;
							// a kind byte that closes the area has no room for a length
							ph = b.last_byte ? PH_BROKEN : PH_LEN;
						end
					end
					PH_LEN: begin
						if (b.byte_value < HDR_LEN ||
						    int'(b.byte_value) > AREA_MAX - int'(opt_start)) begin
							ph = PH_BROKEN;
						end else if (b.byte_value == HDR_LEN) begin
							outs[n] = note_option(6'd0);
							n++;
							ph = PH_KIND;
						end else begin
							body_left = 6'(b.byte_value - HDR_LEN);
							ph = b.last_byte ? PH_BROKEN : PH_BODY;
						end
					end
					PH_BODY: begin
						if (body_left != 0)
							body_left--;
						if (body_left == 0) begin
							outs[n] = note_option(6'(area_pos - opt_start - 6'd2));
							n++;
							ph = PH_KIND;
						end else if (b.last_byte) begin
							// area ends inside an option body
							ph = PH_BROKEN;
						end
					end
					default: ;
				endcase
			end
			if (b.last_byte) begin
				outs[n] = '0;
				outs[n].result_kind  = RK_SUMMARY;
				outs[n].parse_ok     = (ph != PH_BROKEN);
				outs[n].option_count = rec_count;
				n++;
				ph = PH_IDLE;
			end
		end
		if (n > 0)
			outs[n-1].last_result = 1'b1;
		for (int i = 0; i < n; i++)
			pending_results.push_back(outs[i]);
		beats_made = n;
	endtask

	// ---------------------------------------------------------------------
	// checking
	// ---------------------------------------------------------------------

	function automatic void check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$error("tb_top: %s expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endfunction

	// every accepted result beat is matched against the oldest pending one
	always @(posedge clk) begin
		out_beat_t w;
		if (arst_n && res_valid && res_ready) begin
			if (pending_results.size() == 0) begin
				$error("tb_top: result beat with none pending, kind %0d option %0d",
				       res_data.result_kind, res_data.option_kind);
				mismatches++;
			end else begin
				w = pending_results.pop_front();
				check_field("result_kind", 32'(w.result_kind), 32'(res_data.result_kind));
				check_field("option_kind", 32'(w.option_kind), 32'(res_data.option_kind));
				check_field("option_offset", 32'(w.option_offset),
				            32'(res_data.option_offset));
				check_field("body_length", 32'(w.body_length), 32'(res_data.body_length));
				check_field("option_index", 32'(w.option_index),
				            32'(res_data.option_index));
				check_field("present", 32'(w.present), 32'(res_data.present));
				check_field("parse_ok", 32'(w.parse_ok), 32'(res_data.parse_ok));
				check_field("option_count", 32'(w.option_count),
				            32'(res_data.option_count));
				check_field("last_result", 32'(w.last_result), 32'(res_data.last_result));
				case (w.result_kind)
					RK_RECORD: records_seen++;
					RK_SUMMARY: begin
						summaries_seen++;
						if (!w.parse_ok)
							broken_seen++;
					end
					default: begin
						queries_seen++;
						if (w.present)
							query_hits++;
					end
				endcase
			end
		end
	end

	// ---------------------------------------------------------------------
	// stimulus
	// ---------------------------------------------------------------------

	// drives one beat, holds it until accepted, then predicts its results
	task automatic send_beat(input in_beat_t b);
		while (stalls_on && $urandom_range(0, 99) < 8) begin
			opt_valid <= 1'b0;
			@(posedge clk);
		end
		opt_valid <= 1'b1;
		opt_data  <= b;
		@(posedge clk);
		while (!opt_ready)
			@(posedge clk);
		// unused commands and bytes outside an area do nothing, so they are not counted
		if (b.cmd != CMD_UNUSED && !(b.cmd == CMD_BYTE && ph == PH_IDLE))
			beats_counted++;
		parse_beat(b);
	endtask

	// sender goes quiet until every predicted result beat has come back
	task automatic drain_results();
		opt_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	function automatic stim_row_t plain_row(logic [1:0] cmd, logic lst, logic [7:0] val);
		stim_row_t r;
		r.beat.cmd        = cmd;
		r.beat.last_byte  = lst;
		r.beat.byte_value = val;
		r.typed           = 1'b0;
		r.want            = '0;
		return r;
	endfunction

	// row whose final result beat is written out by hand
	function automatic stim_row_t typed_row(logic [1:0] cmd, logic lst, logic [7:0] val,
		logic [1:0] rk, logic [7:0] kind, logic [4:0] idx, logic pres, logic ok,
		logic [4:0] cnt);
		stim_row_t r;
		r = plain_row(cmd, lst, val);
		r.typed              = 1'b1;
		r.want.result_kind   = rk;
		r.want.option_kind   = kind;
		r.want.option_index  = idx;
		r.want.present       = pres;
		r.want.parse_ok      = ok;
		r.want.option_count  = cnt;
		r.want.last_result   = 1'b1;
		return r;
	endfunction

	// fills area_bytes with well-formed options up to limit bytes
	task automatic build_well_formed(input int limit);
		int         room;
		int         blen;
		logic [7:0] k;
		area_bytes.delete();
		while (area_bytes.size() < limit) begin
			room = limit - area_bytes.size();
			case ($urandom_range(0, 9))
				0: area_bytes.push_back(KIND_NOP);
				1: begin
					// end of list, then padding that the parser must skip
					area_bytes.push_back(KIND_EOL);
					while (area_bytes.size() < limit)
						area_bytes.push_back(8'($urandom_range(0, 255)));
				end
				default: begin
					if (room < 2) begin
						area_bytes.push_back(KIND_NOP);
					end else begin
						// a small pool of kinds makes repeats, so latest index matters
						k = $urandom_range(0, 1) ? 8'($urandom_range(2, 9))
						                         : 8'($urandom_range(2, 255));
						if (room - 2 > 6 && $urandom_range(0, 3) != 0)
							blen = $urandom_range(0, 6);
						else
							blen = $urandom_range(0, room - 2);
						area_bytes.push_back(k);
						area_bytes.push_back(8'(blen + 2));
						repeat (blen)
							area_bytes.push_back(8'($urandom_range(0, 255)));
					end
				end
			endcase
		end
	endtask

	// a query for a byte value from the current area or any kind at all
	task automatic send_query();
		in_beat_t b;
		b.cmd       = CMD_QUERY;
		b.last_byte = 1'($urandom_range(0, 1));
		if (area_bytes.size() != 0 && $urandom_range(0, 1))
			b.byte_value = area_bytes[$urandom_range(0, area_bytes.size() - 1)];
		else
			b.byte_value = 8'($urandom_range(0, 255));
		send_beat(b);
	endtask

	// one option area: begin, bytes with queries mixed in, then some follow-up beats
	task automatic run_area();
		in_beat_t b;
		int       limit;
		int       start;
		bit       closed;
		b.cmd        = CMD_BEGIN;
		b.last_byte  = 1'($urandom_range(0, 1));
		b.byte_value = 8'($urandom_range(0, 255));
		send_beat(b);
		limit  = ($urandom_range(0, 4) == 0) ? AREA_MAX : $urandom_range(1, AREA_MAX);
		closed = 1'b1;
		build_well_formed(limit);
		case ($urandom_range(0, 19))
			0, 1: begin
				// cut short, mostly inside an option
				if (area_bytes.size() > 1)
					repeat ($urandom_range(1, area_bytes.size() - 1))
						void'(area_bytes.pop_back());
			end
			2, 3: begin
				// bad length: under two or reaching past the area end
				while (area_bytes.size() > 38)
					void'(area_bytes.pop_back());
				start = area_bytes.size();
				area_bytes.push_back(8'($urandom_range(2, 255)));
				if ($urandom_range(0, 1))
					area_bytes.push_back(8'($urandom_range(0, 1)));
				else
					area_bytes.push_back(8'($urandom_range(AREA_MAX + 1 - start, 255)));
				repeat ($urandom_range(0, 2))
					area_bytes.push_back(8'($urandom_range(0, 255)));
			end
			4: begin
				// more bytes than the area can hold
				build_well_formed(AREA_MAX);
				repeat ($urandom_range(1, 4))
					area_bytes.push_back(8'($urandom_range(0, 255)));
			end
			5: begin
				// kind byte as the final byte
				while (area_bytes.size() > AREA_MAX - 1)
					void'(area_bytes.pop_back());
				area_bytes.push_back(8'($urandom_range(2, 255)));
			end
			6: begin
				area_bytes.delete();
				repeat (limit)
					area_bytes.push_back(8'($urandom_range(0, 255)));
			end
			7: closed = 1'b0;    // left open, the next begin drops it
			default: ;
		endcase
		foreach (area_bytes[i]) begin
			if ($urandom_range(0, 99) < 6)
				send_query();
			b.cmd        = CMD_BYTE;
			b.byte_value = area_bytes[i];
			b.last_byte  = closed && (i == area_bytes.size() - 1);
			send_beat(b);
		end
		repeat ($urandom_range(0, 2))
			send_query();
		if ($urandom_range(0, 9) == 0) begin
			// beats the parser ignores: a byte with no open area, an unused command
			b.cmd        = CMD_BYTE;
			b.last_byte  = 1'($urandom_range(0, 1));
			b.byte_value = 8'($urandom_range(0, 255));
			send_beat(b);
			b.cmd        = CMD_UNUSED;
			b.byte_value = 8'($urandom_range(0, 255));
			send_beat(b);
		end
	endtask

	initial begin
		ref_state_init: begin
			open_area();
		end
		beats_counted  = 0;
		beats_made     = 0;
		mismatches     = 0;
		areas_run      = 0;
		records_seen   = 0;
		summaries_seen = 0;
		broken_seen    = 0;
		queries_seen   = 0;
		query_hits     = 0;

		// directed rows: reset state, a small clean area, the broken cases, then a close on a record
		directed_rows.push_back(typed_row(CMD_QUERY, 1'b0, 8'd0,
			RK_QUERY, 8'd0, 5'd0, 1'b0, 1'b0, 5'd0));
		directed_rows.push_back(typed_row(CMD_QUERY, 1'b1, 8'hFF,
			RK_QUERY, 8'hFF, 5'd0, 1'b0, 1'b0, 5'd0));
		directed_rows.push_back(plain_row(CMD_BEGIN, 1'b1, 8'hA5));
		directed_rows.push_back(plain_row(CMD_BYTE, 1'b0, KIND_NOP));
		directed_rows.push_back(plain_row(CMD_BYTE, 1'b0, 8'd2));
		directed_rows.push_back(plain_row(CMD_BYTE, 1'b0, 8'd4));
		directed_rows.push_back(plain_row(CMD_BYTE, 1'b0, 8'h05));
		directed_rows.push_back(plain_row(CMD_BYTE, 1'b0, 8'hB4));
		directed_rows.push_back(plain_row(CMD_BYTE, 1'b0, 8'hFF));
		directed_rows.push_back(plain_row(CMD_BYTE, 1'b0, HDR_LEN));
		// query right behind the record it asks about
		directed_rows.push_back(typed_row(CMD_QUERY, 1'b0, 8'hFF,
			RK_QUERY, 8'hFF, 5'd1, 1'b1, 1'b0, 5'd0));
		directed_rows.push_back(plain_row(CMD_BYTE, 1'b0, KIND_EOL));
		directed_rows.push_back(typed_row(CMD_BYTE, 1'b1, 8'hFF,
			RK_SUMMARY, 8'd0, 5'd0, 1'b0, 1'b1, 5'd2));
		directed_rows.push_back(typed_row(CMD_QUERY, 1'b0, 8'd2,
			RK_QUERY, 8'd2, 5'd0, 1'b1, 1'b0, 5'd0));
		directed_rows.push_back(plain_row(CMD_BYTE, 1'b1, 8'h12));
		directed_rows.push_back(plain_row(CMD_UNUSED, 1'b1, 8'hFF));
		// length under two
		directed_rows.push_back(plain_row(CMD_BEGIN, 1'b0, 8'h00));
		directed_rows.push_back(plain_row(CMD_BYTE, 1'b0, 8'd7));
		directed_rows.push_back(plain_row(CMD_BYTE, 1'b0, KIND_NOP));
		directed_rows.push_back(typed_row(CMD_BYTE, 1'b1, 8'hFF,
			RK_SUMMARY, 8'd0, 5'd0, 1'b0, 1'b0, 5'd0));
		// kind byte as the last byte
		directed_rows.push_back(plain_row(CMD_BEGIN, 1'b0, 8'h5A));
		directed_rows.push_back(typed_row(CMD_BYTE, 1'b1, 8'd3,
			RK_SUMMARY, 8'd0, 5'd0, 1'b0, 1'b0, 5'd0));
		// last byte completes an option: record, then summary
		directed_rows.push_back(plain_row(CMD_BEGIN, 1'b1, 8'hFF));
		directed_rows.push_back(plain_row(CMD_BYTE, 1'b0, 8'd4));
		directed_rows.push_back(typed_row(CMD_BYTE, 1'b1, HDR_LEN,
			RK_SUMMARY, 8'd0, 5'd0, 1'b0, 1'b1, 5'd1));
		// begin cleared the earlier kinds
		directed_rows.push_back(typed_row(CMD_QUERY, 1'b0, 8'hFF,
			RK_QUERY, 8'hFF, 5'd0, 1'b0, 1'b0, 5'd0));

		repeat (10)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			send_beat(directed_rows[i].beat);
			// the hand-written beat stands in for the predicted final one
			if (directed_rows[i].typed) begin
				if (beats_made > 0)
					pending_results[pending_results.size() - 1] = directed_rows[i].want;
				else
					pending_results.push_back(directed_rows[i].want);
			end
		end
		drain_results();

		// random areas; one stretch of areas runs with no stalls at all
		while (beats_counted < BEAT_TARGET) begin
			stalls_on <= !(areas_run >= 30 && areas_run < 45);
			run_area();
			if (areas_run % 23 == 10)
				drain_results();
			areas_run++;
		end

		drain_results();
		repeat (8)
			@(posedge clk);
		$display("tb_top: %0d beats over %0d random areas; %0d records, %0d summaries",
		         beats_counted, areas_run, records_seen, summaries_seen);
		$display("tb_top: %0d broken areas, %0d queries answered, %0d for a present kind",
		         broken_seen, queries_seen, query_hits);
		if (mismatches == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

	// watchdog, far beyond the slowest correct run
	initial begin
		#(2_000_000);
		$display("tb_top: timeout with %0d result beats still pending", pending_results.size());
		$display("tb_top: done, errors");
		$finish;
	end

endmodule
